@@ src/note_sequencer_tone_player_defines.svh @@
// Assertion macros for the note sequencer tone player.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef NOTE_SEQUENCER_TONE_PLAYER_DEFINES_SVH
`define NOTE_SEQUENCER_TONE_PLAYER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NSTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NSTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/nstp_pkg.sv @@
`timescale 1ns / 1ps

package nstp_pkg;

  // Note table depth and the index widths that follow from it.
  localparam int MAX_NOTES = 256;
  localparam int NOTE_AW   = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int EFF_W     = (NOTE_AW + 1 > 9) ? NOTE_AW + 1 : 9;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Duration arithmetic: a whole note lasts WHOLE_MS / tempo milliseconds.
  localparam int WHOLE_MS = 240000;
  localparam int DVD_W    = 18;
  localparam int DVS_W    = 10;
  localparam int NOM_W    = DVD_W + 1;
  localparam int PCT_W    = 32 + 7;

  // The tone is cut once elapsed * 100 / nominal exceeds 90.
  localparam int PCT_SCALE = 100;
  localparam int PCT_LIMIT = 91;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_PLAY   = 3'd2,
    CMD_STOP   = 3'd3,
    CMD_PAUSE  = 3'd4,
    CMD_RESUME = 3'd5
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMPO    = 2'd0,
    CFG_LOOP     = 2'd1,
    CFG_SONG_LEN = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_DIV1,
    S_DIV2,
    S_APPLY,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [15:0]       freq;
    logic signed [7:0] len;
    logic              tied;
  } note_t;

endpackage

@@ src/nstp_if.sv @@
`timescale 1ns / 1ps

// Command channel into the player.
interface nstp_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        cmd;
  logic [31:0]       now_ms;
  logic [7:0]        note_index;
  logic [15:0]       note_freq;
  logic signed [7:0] note_len;
  logic              note_tied;

  modport source (output valid, cmd, now_ms, note_index, note_freq, note_len, note_tied,
                  input ready);
  modport sink (input valid, cmd, now_ms, note_index, note_freq, note_len, note_tied,
                output ready);
endinterface

// Result channel out of the player.
interface nstp_out_if;
  logic        valid;
  logic        ready;
  logic        tone_on;
  logic [15:0] tone_freq;
  logic        is_playing;
  logic        song_ended;

  modport source (output valid, tone_on, tone_freq, is_playing, song_ended, input ready);
  modport sink (input valid, tone_on, tone_freq, is_playing, song_ended, output ready);
endinterface

@@ src/note_sequencer_tone_player.sv @@
`timescale 1ns / 1ps
`include "note_sequencer_tone_player_defines.svh"

// Command-driven melody player. Notes (frequency, signed length division, tied flag) are
// written into a 256-entry note table RAM; play, stop, pause, resume and millisecond ticks
// drive the song, and every command returns one item with the tone and play status. Items
// are handled one at a time. Write, stop, pause, unknown commands and ticks that need no
// table lookup skip the divider; a resume only reads the table; play and ticks that look
// up a note pass twice through the 18-step serial divider for 240000 / tempo / |length|.
// A new item is accepted while the previous result still waits on the output register.
// The user must write configuration only while the block is idle; nothing enforces it.
module note_sequencer_tone_player (
  input  logic                             clk,
  input  logic                             rst_n,
  nstp_in_if.sink                          in_ch,
  nstp_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [nstp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nstp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import nstp_pkg::*;

  // Configuration registers.
  logic [9:0]         tempo_r;
  logic               loop_r;
  logic [8:0]         song_len_r;

  // Sequencer control.
  state_t             state_r;
  state_t             state_nxt;

  // Item being worked on.
  cmd_t               cmd_r;
  logic [31:0]        now_r;
  logic [31:0]        elapsed_r;
  logic               wr_ok_r;
  logic [NOTE_AW-1:0] wr_addr_r;
  note_t              wr_note_r;

  // Song state.
  logic [NOTE_AW-1:0] cur_idx_r;
  logic [NOTE_AW-1:0] pend_idx_r;
  logic [31:0]        start_r;
  logic [31:0]        remain_r;
  logic               playing_r;
  logic               loaded_r;
  logic               tone_on_r;
  logic [15:0]        tone_freq_r;
  logic               adv_r;
  logic               ended_r;
  logic [NOM_W-1:0]   nom_r;

  // Result register.
  logic               out_valid_r;
  logic               out_tone_on_r;
  logic [15:0]        out_freq_r;
  logic               out_playing_r;
  logic               out_ended_r;

  // Memory and divider hookup.
  logic               mem_rd_en;
  logic [NOTE_AW-1:0] mem_rd_addr;
  logic               mem_wr_en;
  note_t              ent;
  logic               div_start;
  logic [DVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic               div_busy;
  logic               div_done;
  logic [DVD_W-1:0]   div_q;

  // Derived values.
  logic               in_acc;
  logic               out_load;
  logic [EFF_W-1:0]   eff_len;
  logic [EFF_W-1:0]   next_cnt;
  logic               wrap;
  logic [NOTE_AW-1:0] next_idx;
  logic               tick_adv;
  logic [7:0]         mag;
  logic [DVS_W-1:0]   mag_div;
  logic [DVS_W-1:0]   tempo_div;
  logic [DVD_W+1:0]   base3;
  logic [NOM_W-1:0]   nom_calc;
  logic [PCT_W-1:0]   pct_lhs;
  logic [PCT_W-1:0]   pct_rhs;
  logic               pct_hit;
  logic [31:0]        late;
  logic [31:0]        nom_ext;
  logic [31:0]        next_remain;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // Song position arithmetic.
  always_comb begin
    eff_len  = (EFF_W'(song_len_r) < EFF_W'(MAX_NOTES)) ? EFF_W'(song_len_r)
                                                        : EFF_W'(MAX_NOTES);
    next_cnt = EFF_W'(cur_idx_r) + EFF_W'(1);
    wrap     = (next_cnt >= eff_len);
    next_idx = wrap ? '0 : NOTE_AW'(next_cnt);
    tick_adv = (elapsed_r >= remain_r);
  end

  // Divisors for the two division passes; zero counts as one.
  always_comb begin
    mag       = ent.len[7] ? (~ent.len + 8'd1) : ent.len;
    mag_div   = (mag == 8'd0) ? DVS_W'(1) : DVS_W'(mag);
    tempo_div = (tempo_r == 10'd0) ? DVS_W'(1) : DVS_W'(tempo_r);
  end

  // Dotted notes last one and a half times as long, floored.
  always_comb begin
    base3    = {2'b00, div_q} + {1'b0, div_q, 1'b0};
    nom_calc = ent.len[7] ? base3[DVD_W+1:1] : NOM_W'(div_q);
  end

  // Gap test: elapsed * 100 >= nominal * 91, by shifts and adds.
  always_comb begin
    pct_lhs = (PCT_W'(elapsed_r) << 6) + (PCT_W'(elapsed_r) << 5) + (PCT_W'(elapsed_r) << 2);
    pct_rhs = (PCT_W'(nom_r) << 6) + (PCT_W'(nom_r) << 4) + (PCT_W'(nom_r) << 3)
            + (PCT_W'(nom_r) << 1) + PCT_W'(nom_r);
    pct_hit = (pct_lhs >= pct_rhs);
  end

  // Lateness past the end of a note comes off the next one.
  always_comb begin
    late        = elapsed_r - remain_r;
    nom_ext     = 32'(nom_r);
    next_remain = (nom_ext > late) ? (nom_ext - late) : 32'd0;
  end

  // Next state and strobes for memory and divider.
  always_comb begin
    state_nxt   = state_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = cur_idx_r;
    mem_wr_en   = 1'b0;
    div_start   = 1'b0;
    div_dvd     = DVD_W'(WHOLE_MS);
    div_dvs     = tempo_div;
    out_load    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (cmd_r)
          CMD_TICK: begin
            if (playing_r) begin
              if (!tick_adv) begin
                mem_rd_en = 1'b1;
                state_nxt = S_RDWAIT;
              end else if (!wrap || loop_r) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = next_idx;
                state_nxt   = S_RDWAIT;
              end
            end
          end
          CMD_WRITE: begin
            mem_wr_en = wr_ok_r;
          end
          CMD_PLAY: begin
            if (eff_len != '0) begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = '0;
              state_nxt   = S_RDWAIT;
            end
          end
          CMD_RESUME: begin
            if (!playing_r && loaded_r) begin
              mem_rd_en = 1'b1;
              state_nxt = S_RDWAIT;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_RDWAIT: begin
        if (cmd_r == CMD_RESUME) begin
          state_nxt = S_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          div_start = 1'b1;
          div_dvd   = div_q;
          div_dvs   = mag_div;
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_done) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_r    <= 10'd120;
      loop_r     <= 1'b0;
      song_len_r <= 9'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEMPO:    tempo_r    <= cfg_data[9:0];
        CFG_LOOP:     loop_r     <= cfg_data[0];
        CFG_SONG_LEN: song_len_r <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  // Capture of the accepted item.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r          <= cmd_t'(in_ch.cmd);
      now_r          <= in_ch.now_ms;
      elapsed_r      <= in_ch.now_ms - start_r;
      wr_ok_r        <= (int'(in_ch.note_index) < MAX_NOTES);
      wr_addr_r      <= NOTE_AW'(in_ch.note_index);
      wr_note_r.freq <= in_ch.note_freq;
      wr_note_r.len  <= in_ch.note_len;
      wr_note_r.tied <= in_ch.note_tied;
    end
    if (state_r == S_EXEC) begin
      adv_r      <= tick_adv;
      pend_idx_r <= next_idx;
    end
    if (state_r == S_DIV2 && div_done) begin
      nom_r <= nom_calc;
    end
  end

  // Song state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_idx_r   <= '0;
      start_r     <= '0;
      remain_r    <= '0;
      playing_r   <= 1'b0;
      loaded_r    <= 1'b0;
      tone_on_r   <= 1'b0;
      tone_freq_r <= '0;
      ended_r     <= 1'b0;
    end else begin
      if (in_acc) begin
        ended_r <= 1'b0;
      end
      if (state_r == S_EXEC) begin
        // Stop, and a non-looping song running past its last note, clear everything.
        if ((cmd_r == CMD_STOP)
            || (cmd_r == CMD_TICK && playing_r && tick_adv && wrap && !loop_r)) begin
          cur_idx_r   <= '0;
          start_r     <= '0;
          remain_r    <= '0;
          playing_r   <= 1'b0;
          loaded_r    <= 1'b0;
          tone_on_r   <= 1'b0;
          tone_freq_r <= '0;
          ended_r     <= (cmd_r == CMD_TICK);
        end
        // Pause keeps what is left of the current note.
        if (cmd_r == CMD_PAUSE && playing_r) begin
          playing_r   <= 1'b0;
          remain_r    <= (elapsed_r < remain_r) ? (remain_r - elapsed_r) : 32'd0;
          tone_on_r   <= 1'b0;
          tone_freq_r <= '0;
        end
      end
      if (state_r == S_RDWAIT && cmd_r == CMD_RESUME) begin
        playing_r   <= 1'b1;
        start_r     <= now_r;
        tone_on_r   <= (ent.freq != 16'd0);
        tone_freq_r <= ent.freq;
      end
      if (state_r == S_APPLY) begin
        if (cmd_r == CMD_PLAY) begin
          playing_r   <= 1'b1;
          loaded_r    <= 1'b1;
          cur_idx_r   <= '0;
          start_r     <= now_r;
          remain_r    <= nom_ext;
          tone_on_r   <= (ent.freq != 16'd0);
          tone_freq_r <= ent.freq;
        end else if (!adv_r) begin
          // Untied notes go silent near their end.
          if (!ent.tied && nom_r != '0 && pct_hit) begin
            tone_on_r   <= 1'b0;
            tone_freq_r <= '0;
          end
        end else begin
          cur_idx_r   <= pend_idx_r;
          start_r     <= now_r;
          remain_r    <= next_remain;
          tone_on_r   <= (ent.freq != 16'd0);
          tone_freq_r <= ent.freq;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tone_on_r <= tone_on_r;
      out_freq_r    <= tone_on_r ? tone_freq_r : 16'd0;
      out_playing_r <= playing_r;
      out_ended_r   <= ended_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.tone_on    = out_tone_on_r;
  assign out_ch.tone_freq  = out_freq_r;
  assign out_ch.is_playing = out_playing_r;
  assign out_ch.song_ended = out_ended_r;

  nstp_note_ram u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (wr_addr_r),
    .wr_data (wr_note_r),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (ent)
  );

  nstp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Checks.
  `NSTP_ASSERT_NOW(a_idle_div, state_r == S_IDLE, !div_busy, "divider busy while idle")
  `NSTP_ASSERT_NOW(a_play_loaded, playing_r, loaded_r, "playing without a loaded song")
  `NSTP_ASSERT_NEXT(a_one_item, in_acc, !in_ch.ready, "second item taken while busy")
  `NSTP_ASSERT_NOW(a_ended_quiet, out_ch.valid && out_ch.song_ended,
                   !out_ch.is_playing && !out_ch.tone_on, "ended song still sounding")

endmodule

@@ src/nstp_note_ram.sv @@
`timescale 1ns / 1ps

module nstp_note_ram (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [nstp_pkg::NOTE_AW-1:0] wr_addr,
  input  nstp_pkg::note_t         wr_data,
  input  logic                    rd_en,
  input  logic [nstp_pkg::NOTE_AW-1:0] rd_addr,
  output nstp_pkg::note_t         rd_data
);
  import nstp_pkg::*;

  note_t mem [MAX_NOTES];
  note_t rd_data_r;

  // One write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // One read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/nstp_div.sv @@
`timescale 1ns / 1ps

module nstp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [nstp_pkg::DVD_W-1:0]  dividend,
  input  logic [nstp_pkg::DVS_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [nstp_pkg::DVD_W-1:0]  quotient
);
  import nstp_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  // One restoring step: bring down the next dividend bit and try the subtract.
  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = (trial >= {1'b0, dvs_r});
  end

  // Step counter and handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r  <= CNT_W'(DVD_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient shifts in from the right as the dividend shifts out on the left.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule
